FILE: rtl/core/cau_pkg.sv
// shared types, constants and helper functions of the complex arithmetic unit
package cau_pkg;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_POLAR = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_SAT     = 2'd2
  } status_e;

  // divider: one precheck stage plus one stage per quotient bit
  localparam int unsigned QW       = 33;
  localparam int unsigned DIV_LAT  = QW + 1;
  localparam int unsigned SQRT_LAT = 32;
  // cordic datapath widths
  localparam int unsigned XW = 35;
  localparam int unsigned ZW = 32;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } sat_val_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] re;
    logic [31:0] im;
  } cplx_t;

  typedef struct packed {
    logic    valid;
    op_e     op;
    logic    dz;
  } ctl_t;

  // sign and magnitude to a saturated 32-bit word
  function automatic sat_val_t sat_pack(input logic neg, input logic [63:0] mag);
    sat_val_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        r.sat = 1'b1;
        r.val = 32'h8000_0000;
      end else begin
        r.val = (~mag[31:0]) + 32'd1;
      end
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) begin
        r.sat = 1'b1;
        r.val = 32'h7FFF_FFFF;
      end else begin
        r.val = mag[31:0];
      end
    end
    return r;
  endfunction

  // atan(2^-i) in q2.30
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd843314856;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043836;
      5'd3:  v = 32'd133525158;
      5'd4:  v = 32'd67021686;
      5'd5:  v = 32'd33543515;
      5'd6:  v = 32'd16775850;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194282;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048575;
      5'd11: v = 32'd524287;
      5'd12: v = 32'd262143;
      5'd13: v = 32'd131071;
      5'd14: v = 32'd65535;
      5'd15: v = 32'd32767;
      5'd16: v = 32'd16383;
      5'd17: v = 32'd8191;
      5'd18: v = 32'd4095;
      5'd19: v = 32'd2047;
      5'd20: v = 32'd1023;
      5'd21: v = 32'd511;
      5'd22: v = 32'd255;
      5'd23: v = 32'd127;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // q2.30 angle rounded to f fraction bits
  function automatic logic [31:0] scale_angle(input logic [31:0] q30, input int unsigned f);
    logic [32:0] t;
    t = {1'b0, q30} + (33'd1 << (29 - f));
    return 32'(t >> (30 - f));
  endfunction

endpackage

FILE: rtl/core/cau_if.sv
// request and response channel interfaces of the complex arithmetic unit
interface cau_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] a_re;
  logic signed [31:0] a_im;
  logic signed [31:0] b_re;
  logic signed [31:0] b_im;

  modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_re;
  logic signed [31:0] res_im;
  logic [1:0]         status;

  modport source (output valid, res_re, res_im, status, input ready);
  modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

FILE: rtl/core/cau_delay.sv
// enabled shift line that keeps side data aligned with the long pipelines
module cau_delay #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] line_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < int'(DEPTH); k++) line_q[k] <= '0;
    end else if (en_i) begin
      line_q[0] <= d_i;
      for (int k = 1; k < int'(DEPTH); k++) line_q[k] <= line_q[k-1];
    end
  end

  assign q_o = line_q[DEPTH-1];

endmodule

FILE: rtl/core/cau_div_pipe.sv
// pipelined restoring divider: floor(n * 2^frac / d), one quotient bit per stage
module cau_div_pipe #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [63:0]            n_i,
  input  logic [63:0]            d_i,
  output logic [cau_pkg::QW-1:0] q_o,
  output logic                   ovf_o
);

  localparam int unsigned SH = cau_pkg::QW - FRAC_BITS;
  localparam int unsigned NS = cau_pkg::DIV_LAT;

  logic [63:0]            n_q   [NS];
  logic [63:0]            d_q   [NS];
  logic [63:0]            r_q   [NS];
  logic [cau_pkg::QW-1:0] q_q   [NS];
  logic                   ovf_q [NS];

  // quotient of 2^33 or more saturates anyway
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]   <= n_i;
      d_q[0]   <= d_i;
      r_q[0]   <= n_i >> SH;
      ovf_q[0] <= (n_i >> SH) >= d_i;
      q_q[0]   <= '0;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_stage
    localparam int unsigned BI = NS - 1 - k;
    logic        nbit;
    logic [64:0] r2;
    logic [64:0] diff;
    logic        ge;

    if (BI >= FRAC_BITS) begin : g_bit
      assign nbit = n_q[k-1][BI-FRAC_BITS];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign r2   = {r_q[k-1], nbit};
    assign diff = r2 - {1'b0, d_q[k-1]};
    assign ge   = r2 >= {1'b0, d_q[k-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]   <= n_q[k-1];
        d_q[k]   <= d_q[k-1];
        r_q[k]   <= ge ? diff[63:0] : r2[63:0];
        q_q[k]   <= {q_q[k-1][cau_pkg::QW-2:0], ge};
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign q_o   = q_q[NS-1];
  assign ovf_o = ovf_q[NS-1];

endmodule

FILE: rtl/core/cau_sqrt_pipe.sv
// pipelined integer square root, one root bit per stage
module cau_sqrt_pipe (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] s_i,
  output logic [31:0] root_o
);

  localparam int unsigned NS = cau_pkg::SQRT_LAT;

  logic [63:0] s_q    [NS];
  logic [33:0] rem_q  [NS];
  logic [31:0] root_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [63:0] s_in;
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [35:0] r2;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign s_in    = s_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign s_in    = s_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign r2    = {rem_in, s_in[63:62]};
    assign trial = {2'b00, root_in, 2'b01};
    assign diff  = r2 - trial;
    assign ge    = r2 >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k]    <= {s_in[61:0], 2'b00};
        rem_q[k]  <= ge ? diff[33:0] : r2[33:0];
        root_q[k] <= {root_in[30:0], ge};
      end
    end
  end

  assign root_o = root_q[NS-1];

endmodule

FILE: rtl/core/cau_cordic.sv
// vectoring cordic: angle of (x, y) with quadrant fold, one rotation per stage
module cau_cordic #(
  parameter int unsigned FRAC_BITS     = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [31:0]            x_i,
  input  logic signed [31:0]            y_i,
  output logic signed [cau_pkg::ZW-1:0] z_o
);

  localparam int unsigned XW = cau_pkg::XW;
  localparam int unsigned ZW = cau_pkg::ZW;
  localparam logic [31:0] PI_S = cau_pkg::scale_angle(cau_pkg::PI_Q30, FRAC_BITS);

  logic signed [XW-1:0] x_q [CORDIC_STAGES+1];
  logic signed [XW-1:0] y_q [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_q [CORDIC_STAGES+1];

  // left half plane folds over by pi: x and y are negated and the start angle takes the sign of y
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (x_i[31]) begin
        x_q[0] <= -XW'(x_i);
        y_q[0] <= -XW'(y_i);
        z_q[0] <= y_i[31] ? -$signed(PI_S) : $signed(PI_S);
      end else begin
        x_q[0] <= XW'(x_i);
        y_q[0] <= XW'(y_i);
        z_q[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    localparam logic [31:0] T = cau_pkg::scale_angle(cau_pkg::atan_q30(5'(k)), FRAC_BITS);
    logic ypos;
    logic yneg;

    assign yneg = y_q[k][XW-1];
    assign ypos = !yneg && (y_q[k] != '0);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (ypos) begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] + $signed(T);
        end else if (yneg) begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] - $signed(T);
        end else begin
          x_q[k+1] <= x_q[k];
          y_q[k+1] <= y_q[k];
          z_q[k+1] <= z_q[k];
        end
      end
    end
  end

  assign z_o = z_q[CORDIC_STAGES];

endmodule

FILE: rtl/core/complex_arithmetic_unit.sv
// Complex-number ALU in signed fixed point: add, subtract, multiply, divide and polar form.
// One word is accepted every cycle while the output is not stalled; the depth of the pipeline
// is set by the divider, a restoring pipeline that resolves
// one quotient bit per stage, and the square root and cordic paths are padded to match.
// The whole pipeline advances together: while a result sits in the output register
// and is not taken, no stage moves and no new request is accepted.
module complex_arithmetic_unit #(
  parameter int unsigned FRAC_BITS     = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cau_req_if.sink    req_i,
  cau_rsp_if.source  rsp_o
);

  localparam int unsigned ALIGN = 4 + cau_pkg::DIV_LAT;

  logic en;

  // stage a: input registers
  cau_pkg::ctl_t      a_ctl_q;
  logic signed [31:0] a_ar_q, a_ai_q, a_br_q, a_bi_q;

  // stage b: products and add/sub
  cau_pkg::op_e       b_op_q;
  logic signed [63:0] b_rr_q, b_ii_q, b_ri_q, b_ir_q, b_sq0_q, b_sq1_q;
  cau_pkg::cplx_t     b_as_q;
  cau_pkg::cplx_t     as_d;

  // stage c: wide sums
  logic signed [64:0] c_nr_q, c_ni_q;
  logic [63:0]        c_s_q;

  // stage d: magnitudes
  logic [63:0]        d_mre_q, d_mim_q, d_den_q;
  logic [1:0]         d_neg_q;

  // stage e: product packed
  cau_pkg::cplx_t     e_mul_q;
  cau_pkg::sat_val_t  mre_p, mim_p;

  // aligned outputs
  cau_pkg::ctl_t      f_ctl;
  cau_pkg::cplx_t     f_as, f_mul;
  logic [1:0]         f_neg;
  logic [31:0]        root, f_root;
  logic signed [31:0] ang, f_ang;
  logic [cau_pkg::QW-1:0] q_re, q_im;
  logic               ovf_re, ovf_im;

  // output register
  logic               rsp_valid_q;
  logic signed [31:0] rsp_re_q, rsp_im_q;
  cau_pkg::status_e   rsp_st_q;
  logic signed [31:0] res_re_d, res_im_d;
  cau_pkg::status_e   rsp_st_d;

  assign en          = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctl_q <= '0;
    end else if (en) begin
      a_ctl_q.valid <= req_i.valid;
      a_ctl_q.op    <= cau_pkg::op_e'(req_i.req_type);
      a_ctl_q.dz    <= (req_i.b_re == '0) && (req_i.b_im == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ar_q <= req_i.a_re;
      a_ai_q <= req_i.a_im;
      a_br_q <= req_i.b_re;
      a_bi_q <= req_i.b_im;
    end
  end

  // add/sub with saturation
  always_comb begin
    logic signed [32:0] sr, si;
    logic [32:0]        mr, mi;
    cau_pkg::sat_val_t  pr, pi;
    if (a_ctl_q.op == cau_pkg::OP_SUB) begin
      sr = 33'(a_ar_q) - 33'(a_br_q);
      si = 33'(a_ai_q) - 33'(a_bi_q);
    end else begin
      sr = 33'(a_ar_q) + 33'(a_br_q);
      si = 33'(a_ai_q) + 33'(a_bi_q);
    end
    mr = sr[32] ? 33'(-sr) : 33'(sr);
    mi = si[32] ? 33'(-si) : 33'(si);
    pr = cau_pkg::sat_pack(sr[32], {31'b0, mr});
    pi = cau_pkg::sat_pack(si[32], {31'b0, mi});
    as_d.sat = pr.sat || pi.sat;
    as_d.re  = pr.val;
    as_d.im  = pi.val;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_op_q <= a_ctl_q.op;
      b_as_q <= as_d;
      b_rr_q <= a_ar_q * a_br_q;
      b_ii_q <= a_ai_q * a_bi_q;
      b_ri_q <= a_ar_q * a_bi_q;
      b_ir_q <= a_ai_q * a_br_q;
      // squares feed |b|^2 for divide or |a|^2 for polar
      if (a_ctl_q.op == cau_pkg::OP_POLAR) begin
        b_sq0_q <= a_ar_q * a_ar_q;
        b_sq1_q <= a_ai_q * a_ai_q;
      end else begin
        b_sq0_q <= a_br_q * a_br_q;
        b_sq1_q <= a_bi_q * a_bi_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (b_op_q == cau_pkg::OP_MUL) begin
        c_nr_q <= 65'(b_rr_q) - 65'(b_ii_q);
        c_ni_q <= 65'(b_ri_q) + 65'(b_ir_q);
      end else begin
        c_nr_q <= 65'(b_rr_q) + 65'(b_ii_q);
        c_ni_q <= 65'(b_ir_q) - 65'(b_ri_q);
      end
      c_s_q <= 64'(b_sq0_q) + 64'(b_sq1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_neg_q <= {c_nr_q[64], c_ni_q[64]};
      d_mre_q <= c_nr_q[64] ? 64'(-c_nr_q) : c_nr_q[63:0];
      d_mim_q <= c_ni_q[64] ? 64'(-c_ni_q) : c_ni_q[63:0];
      d_den_q <= c_s_q;
    end
  end

  assign mre_p = cau_pkg::sat_pack(d_neg_q[1], d_mre_q >> FRAC_BITS);
  assign mim_p = cau_pkg::sat_pack(d_neg_q[0], d_mim_q >> FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_mul_q.sat <= mre_p.sat || mim_p.sat;
      e_mul_q.re  <= mre_p.val;
      e_mul_q.im  <= mim_p.val;
    end
  end

  cau_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_re (
    .clk_i, .en_i(en), .n_i(d_mre_q), .d_i(d_den_q), .q_o(q_re), .ovf_o(ovf_re)
  );

  cau_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_im (
    .clk_i, .en_i(en), .n_i(d_mim_q), .d_i(d_den_q), .q_o(q_im), .ovf_o(ovf_im)
  );

  cau_sqrt_pipe u_sqrt (
    .clk_i, .en_i(en), .s_i(c_s_q), .root_o(root)
  );

  cau_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk_i, .en_i(en), .x_i(a_ar_q), .y_i(a_ai_q), .z_o(ang)
  );

  cau_delay #(.W($bits(cau_pkg::ctl_t)), .DEPTH(ALIGN - 1)) u_dly_ctl (
    .clk_i, .rst_ni, .en_i(en), .d_i(a_ctl_q), .q_o(f_ctl)
  );

  cau_delay #(.W($bits(cau_pkg::cplx_t)), .DEPTH(ALIGN - 2)) u_dly_as (
    .clk_i, .rst_ni, .en_i(en), .d_i(b_as_q), .q_o(f_as)
  );

  cau_delay #(.W($bits(cau_pkg::cplx_t)), .DEPTH(ALIGN - 5)) u_dly_mul (
    .clk_i, .rst_ni, .en_i(en), .d_i(e_mul_q), .q_o(f_mul)
  );

  cau_delay #(.W(2), .DEPTH(ALIGN - 4)) u_dly_neg (
    .clk_i, .rst_ni, .en_i(en), .d_i(d_neg_q), .q_o(f_neg)
  );

  cau_delay #(.W(32), .DEPTH(ALIGN - 3 - cau_pkg::SQRT_LAT)) u_dly_root (
    .clk_i, .rst_ni, .en_i(en), .d_i(root), .q_o(f_root)
  );

  cau_delay #(.W(32), .DEPTH(ALIGN - 2 - CORDIC_STAGES)) u_dly_ang (
    .clk_i, .rst_ni, .en_i(en), .d_i(ang), .q_o(f_ang)
  );

  // result select
  always_comb begin
    cau_pkg::sat_val_t pr, pi;
    logic              sat;
    logic [63:0]       mag_re, mag_im;
    res_re_d = '0;
    res_im_d = '0;
    rsp_st_d = cau_pkg::ST_OK;
    sat      = 1'b0;
    mag_re   = ovf_re ? 64'h0000_0002_0000_0000 : {{(64 - cau_pkg::QW){1'b0}}, q_re};
    mag_im   = ovf_im ? 64'h0000_0002_0000_0000 : {{(64 - cau_pkg::QW){1'b0}}, q_im};
    pr       = cau_pkg::sat_pack(f_neg[1], mag_re);
    pi       = cau_pkg::sat_pack(f_neg[0], mag_im);
    unique case (f_ctl.op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        res_re_d = f_as.re;
        res_im_d = f_as.im;
        sat      = f_as.sat;
      end
      cau_pkg::OP_MUL: begin
        res_re_d = f_mul.re;
        res_im_d = f_mul.im;
        sat      = f_mul.sat;
      end
      cau_pkg::OP_DIV: begin
        if (f_ctl.dz) begin
          rsp_st_d = cau_pkg::ST_DIVZERO;
        end else begin
          res_re_d = pr.val;
          res_im_d = pi.val;
          sat      = pr.sat || pi.sat;
        end
      end
      cau_pkg::OP_POLAR: begin
        res_re_d = f_root[31] ? 32'h7FFF_FFFF : f_root;
        res_im_d = f_ang;
        sat      = f_root[31];
      end
      default: begin
        res_re_d = '0;
        res_im_d = '0;
      end
    endcase
    if (sat && rsp_st_d == cau_pkg::ST_OK) rsp_st_d = cau_pkg::ST_SAT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (en) begin
      rsp_valid_q <= f_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsp_re_q <= res_re_d;
      rsp_im_q <= res_im_d;
      rsp_st_q <= rsp_st_d;
    end
  end

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.res_re = rsp_re_q;
  assign rsp_o.res_im = rsp_im_q;
  assign rsp_o.status = rsp_st_q;

endmodule

FILE: bench/tb_top.sv
// self-checking bench for the complex arithmetic unit: directed table then random words
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned N_RANDOM   = 1230;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam logic [63:0] PI_WORD    = 64'd3373259426;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] a_re, a_im, b_re, b_im;
  } req_t;

  typedef struct {
    logic [31:0] re, im;
    logic [1:0]  st;
  } res_t;

  typedef struct {
    req_t rq;
    bit   typed;
    res_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors = 0;
  int   idle_cycles = 0;
  bit   burst = 1'b0;
  res_t pending_q[$];

  cau_req_if req();
  cau_rsp_if rsp();

  complex_arithmetic_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  always #6 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic logic [31:0] to_word(input bit neg, input logic [63:0] mag,
                                          inout bit sat);
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return ~mag[31:0] + 32'd1;
    end
    if (mag > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return mag[31:0];
  endfunction

  // value formed modulo 2^64 whose true range is (-2^63, 2^63]
  function automatic logic [63:0] split_sign(input logic [63:0] s, output bit neg);
    neg = s[63] && (s != 64'h8000_0000_0000_0000);
    return neg ? (~s + 64'd1) : s;
  endfunction

  function automatic logic [63:0] quot_fixed(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] r, q;
    bit b;
    r = '0;
    q = '0;
    for (int i = 63 + 16; i >= 0; i--) begin
      b = (i >= 16) ? n[i-16] : 1'b0;
      r = {r[62:0], b};
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
      if (q > (64'd1 << 33)) q = 64'd1 << 33;
    end
    return q;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] s);
    logic [63:0] res, b;
    res = '0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint round_angle(input logic [63:0] q30);
    return longint'((q30 + 64'd8192) >> 14);
  endfunction

  function automatic longint vector_angle(input longint x, input longint y);
    longint z, dx, dy, t;
    logic [63:0] tbl [16];
    tbl = '{64'd843314856, 64'd497837829, 64'd263043836, 64'd133525158,
            64'd67021686, 64'd33543515, 64'd16775850, 64'd8388437,
            64'd4194282, 64'd2097149, 64'd1048575, 64'd524287,
            64'd262143, 64'd131071, 64'd65535, 64'd32767};
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? round_angle(PI_WORD) : -round_angle(PI_WORD);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      t = round_angle(tbl[i]);
      if (y > 0) begin
        x += dx; y -= dy; z += t;
      end else if (y < 0) begin
        x -= dx; y += dy; z -= t;
      end
    end
    return z;
  endfunction

  function automatic res_t cplx_result(input req_t rq);
    res_t   r;
    longint ar, ai, br, bi, sr, si, ang;
    logic [63:0] mr, mi, den;
    bit     sat, nr, ni;
    ar = longint'($signed(rq.a_re));
    ai = longint'($signed(rq.a_im));
    br = longint'($signed(rq.b_re));
    bi = longint'($signed(rq.b_im));
    r = '{32'd0, 32'd0, cau_pkg::ST_OK};
    sat = 1'b0;
    case (rq.op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        sr = (rq.op == cau_pkg::OP_ADD) ? ar + br : ar - br;
        si = (rq.op == cau_pkg::OP_ADD) ? ai + bi : ai - bi;
        r.re = to_word(sr < 0, sr < 0 ? -sr : sr, sat);
        r.im = to_word(si < 0, si < 0 ? -si : si, sat);
      end
      cau_pkg::OP_MUL: begin
        mr = split_sign(64'(ar * br) - 64'(ai * bi), nr);
        mi = split_sign(64'(ar * bi) + 64'(ai * br), ni);
        r.re = to_word(nr, mr >> 16, sat);
        r.im = to_word(ni, mi >> 16, sat);
      end
      cau_pkg::OP_DIV: begin
        den = 64'(br * br) + 64'(bi * bi);
        if (den == 0) begin
          r.st = cau_pkg::ST_DIVZERO;
        end else begin
          mr = split_sign(64'(ar * br) + 64'(ai * bi), nr);
          mi = split_sign(64'(ai * br) - 64'(ar * bi), ni);
          r.re = to_word(nr, quot_fixed(mr, den), sat);
          r.im = to_word(ni, quot_fixed(mi, den), sat);
        end
      end
      cau_pkg::OP_POLAR: begin
        ang = vector_angle(ar, ai);
        r.re = to_word(1'b0, int_sqrt(64'(ar * ar) + 64'(ai * ai)), sat);
        r.im = to_word(ang < 0, ang < 0 ? -ang : ang, sat);
      end
      default: ;
    endcase
    if (sat && r.st == cau_pkg::ST_OK) r.st = cau_pkg::ST_SAT;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // ---------------- stimulus ----------------
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6:    return 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
      7:          return 32'($signed($urandom_range(0, 2048)) - 1024);
      8:          return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default:    return 32'($urandom_range(0, 1) ? 0 : 32'h0001_0000);
    endcase
  endfunction

  task automatic send_word(input req_t rq);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.req_type <= rq.op;
    req.a_re     <= rq.a_re;
    req.a_im     <= rq.a_im;
    req.b_re     <= rq.b_re;
    req.b_im     <= rq.b_im;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_q.push_back(cplx_result(rq));
  endtask

  initial begin
    row_t rows[$];
    req_t rq;
    res_t pred;
    req.valid    <= 1'b0;
    req.req_type <= cau_pkg::OP_ADD;
    req.a_re     <= '0;
    req.a_im     <= '0;
    req.b_re     <= '0;
    req.b_im     <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows = '{
      '{'{cau_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
        1'b1, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, cau_pkg::ST_SAT}},
      '{'{cau_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
        1'b1, '{32'h8000_0000, 32'h8000_0000, cau_pkg::ST_SAT}},
      '{'{cau_pkg::OP_SUB, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0}, 1'b1,
        '{32'h8000_0000, 32'h0, cau_pkg::ST_SAT}},
      '{'{cau_pkg::OP_SUB, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000},
        1'b1, '{32'h0002_0000, 32'hFFFF_0000, cau_pkg::ST_OK}},
      '{'{cau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
        1'b0, '{0, 0, cau_pkg::ST_OK}},
      '{'{cau_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
        1'b0, '{0, 0, cau_pkg::ST_OK}},
      '{'{cau_pkg::OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h0001_8000},
        1'b0, '{0, 0, cau_pkg::ST_OK}},
      '{'{cau_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0}, 1'b1,
        '{32'h0, 32'h0, cau_pkg::ST_DIVZERO}},
      '{'{cau_pkg::OP_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000},
        1'b0, '{0, 0, cau_pkg::ST_OK}},
      '{'{cau_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0}, 1'b0,
        '{0, 0, cau_pkg::ST_OK}},
      '{'{cau_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
        1'b0, '{0, 0, cau_pkg::ST_OK}},
      '{'{cau_pkg::OP_POLAR, 32'h0, 32'h0, 32'h1234_5678, 32'h0}, 1'b1,
        '{32'h0, 32'h0, cau_pkg::ST_OK}},
      '{'{cau_pkg::OP_POLAR, 32'hFFFE_0000, 32'h0, 32'h0, 32'h0}, 1'b0,
        '{0, 0, cau_pkg::ST_OK}},
      '{'{cau_pkg::OP_POLAR, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0}, 1'b0,
        '{0, 0, cau_pkg::ST_OK}},
      '{'{cau_pkg::OP_POLAR, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0}, 1'b0,
        '{0, 0, cau_pkg::ST_OK}},
      '{'{cau_pkg::OP_POLAR, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0}, 1'b0,
        '{0, 0, cau_pkg::ST_OK}},
      '{'{3'd5, 32'h7FFF_FFFF, 32'h1, 32'h2, 32'h3}, 1'b1,
        '{32'h0, 32'h0, cau_pkg::ST_OK}},
      '{'{3'd6, 32'h8000_0000, 32'h1, 32'h2, 32'h3}, 1'b1,
        '{32'h0, 32'h0, cau_pkg::ST_OK}},
      '{'{3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
        '{32'h0, 32'h0, cau_pkg::ST_OK}}
    };

    foreach (rows[i]) begin
      // typed rows also cross-check the predictor itself
      if (rows[i].typed) begin
        pred = cplx_result(rows[i].rq);
        if (pred != rows[i].want) report_mismatch($sformatf("table row %0d", i),
                                                  pred.re, rows[i].want.re);
      end
      send_word(rows[i].rq);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 200 == 100) burst = ~burst;
      // drain once so the sender sees an empty pipeline
      if (n == 600) begin
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0) @(posedge clk);
      end
      rq.op   = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
      rq.a_re = pick_operand();
      rq.a_im = pick_operand();
      rq.b_re = pick_operand();
      rq.b_im = pick_operand();
      if (rq.op == cau_pkg::OP_DIV && $urandom_range(0, 15) == 0) begin
        rq.b_re = '0;
        rq.b_im = '0;
      end
      send_word(rq);
    end
    req.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------- response side ----------------
  initial begin
    res_t want;
    int   stall;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected word", rsp.res_re, 32'h0);
      end else begin
        want = pending_q.pop_front();
        if (rsp.res_re !== want.re) report_mismatch("res_re", rsp.res_re, want.re);
        if (rsp.res_im !== want.im) report_mismatch("res_im", rsp.res_im, want.im);
        if (rsp.status !== want.st) report_mismatch("status", 32'(rsp.status), 32'(want.st));
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule

FILE: sim.f
rtl/core/cau_pkg.sv
rtl/core/cau_if.sv
rtl/core/cau_delay.sv
rtl/core/cau_div_pipe.sv
rtl/core/cau_sqrt_pipe.sv
rtl/core/cau_cordic.sv
rtl/core/complex_arithmetic_unit.sv
bench/tb_top.sv
